// ===== hdl/assert_macros.svh =====
// Assertion macros used by the checker file of this project.
// Depends on nothing; take in by `include with the bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// hold c in the same cycle as a
`define ASSERT_IMPLY(label, clk, rst_n, a, c, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |-> (c)) \
		else $error(msg);

// hold c in the cycle after a
`define ASSERT_NEXT(label, clk, rst_n, a, c, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |=> (c)) \
		else $error(msg);

`endif

// ===== hdl/cfwr_pkg.sv =====
// Types and codes for the circular FIFO with replace.
// Depends on nothing; used by the cell, the top level and the checker.
`timescale 1ns / 1ps

package cfwr_pkg;

	localparam int unsigned WORD_W = 32;
	localparam int unsigned OCC_W  = 8;

	typedef enum logic [1:0] {
		FUNC_ENQ = 2'd0,
		FUNC_DEQ = 2'd1,
		FUNC_REP = 2'd2
	} func_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_OVERFLOW  = 2'd1,
		ST_UNDERFLOW = 2'd2
	} status_t;

	localparam logic [WORD_W-1:0] UNDERFLOW_WORD = '1;

	typedef struct packed {
		logic              enq;
		logic              deq;
		logic              rep;
		logic [WORD_W-1:0] value;
		logic [WORD_W-1:0] new_value;
	} cell_ctrl_t;

endpackage

// ===== hdl/circular_fifo_with_replace.sv =====
// Top level of the FIFO with replace: a row of cells, head at cell 0.
// Depends on cfwr_pkg and cfwr_cell.
//
//  channel | handshake            | payload
//  --------+----------------------+------------------------------
//  request | req_valid, req_stall | func, value, new_value
//  result  | rsp_valid, rsp_stall | read_data, status, occupancy
//
// Every operation, replace included, is done over the whole row in parallel: all cells
// compare against the target at once and shift together on dequeue.
// One result per request, registered in the cycle after the request transfer.
// Reset empties the queue and the result register at once.
// req_stall follows rsp_stall while a result is held.
`timescale 1ns / 1ps

module circular_fifo_with_replace #(
	parameter int unsigned DEPTH = 128
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_stall,
	input  logic [1:0]          func,
	input  logic signed [31:0]  value,
	input  logic signed [31:0]  new_value,
	output logic                rsp_valid,
	input  logic                rsp_stall,
	output logic signed [31:0]  read_data,
	output logic [1:0]          status,
	output logic [7:0]          occupancy
);

	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	logic [DEPTH+1:0]                  v_ext;
	logic [cfwr_pkg::WORD_W-1:0]       d_ext [DEPTH+1];
	cfwr_pkg::cell_ctrl_t              ctrl;
	logic                              req_accept;
	logic                              full;
	logic                              empty;
	logic [CNT_W-1:0]                  count_q;
	logic [CNT_W-1:0]                  count_next;
	logic [CNT_W+cfwr_pkg::OCC_W-1:0]  count_ext;
	logic [cfwr_pkg::WORD_W-1:0]       rd_next;
	cfwr_pkg::status_t                 st_next;

	logic                              rsp_valid_q;
	logic [cfwr_pkg::WORD_W-1:0]       read_data_q;
	cfwr_pkg::status_t                 status_q;
	logic [cfwr_pkg::OCC_W-1:0]        occupancy_q;

	assign req_stall  = rsp_valid_q && rsp_stall;
	assign req_accept = req_valid && !req_stall;

	assign v_ext[0]       = 1'b1;
	assign v_ext[DEPTH+1] = 1'b0;
	assign d_ext[DEPTH]   = '0;
	assign full           = v_ext[DEPTH];
	assign empty          = !v_ext[1];

	always_comb begin
		ctrl.enq       = 1'b0;
		ctrl.deq       = 1'b0;
		ctrl.rep       = 1'b0;
		ctrl.value     = value;
		ctrl.new_value = new_value;
		rd_next        = '0;
		st_next        = cfwr_pkg::ST_OK;
		count_next     = count_q;
		unique case (func)
			cfwr_pkg::FUNC_ENQ: begin
				if (full) begin
					st_next = cfwr_pkg::ST_OVERFLOW;
				end else begin
					ctrl.enq   = req_accept;
					count_next = count_q + CNT_W'(1);
				end
			end
			cfwr_pkg::FUNC_DEQ: begin
				if (empty) begin
					rd_next = cfwr_pkg::UNDERFLOW_WORD;
					st_next = cfwr_pkg::ST_UNDERFLOW;
				end else begin
					rd_next    = d_ext[0];
					ctrl.deq   = req_accept;
					count_next = count_q - CNT_W'(1);
				end
			end
			cfwr_pkg::FUNC_REP: begin
				ctrl.rep = req_accept;
			end
			default: begin
			end
		endcase
	end

	assign count_ext = {{cfwr_pkg::OCC_W{1'b0}}, count_next};

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		cfwr_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctrl       (ctrl),
			.prev_valid (v_ext[i]),
			.next_valid (v_ext[i+2]),
			.next_data  (d_ext[i+1]),
			.valid      (v_ext[i+1]),
			.data       (d_ext[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (req_accept) begin
				count_q     <= count_next;
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// hold the result payload until its transfer
	always_ff @(posedge clk) begin
		if (req_accept) begin
			read_data_q <= rd_next;
			status_q    <= st_next;
			occupancy_q <= count_ext[cfwr_pkg::OCC_W-1:0];
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign read_data = read_data_q;
	assign status    = status_q;
	assign occupancy = occupancy_q;

endmodule

// ===== hdl/cfwr_cell.sv =====
// One storage cell of the FIFO row: a word and its occupied flag.
// Depends on cfwr_pkg; instantiated in a row by circular_fifo_with_replace.
`timescale 1ns / 1ps

module cfwr_cell (
	input  logic                             clk,
	input  logic                             arst_n,
	input  cfwr_pkg::cell_ctrl_t             ctrl,
	input  logic                             prev_valid,
	input  logic                             next_valid,
	input  logic [cfwr_pkg::WORD_W-1:0]      next_data,
	output logic                             valid,
	output logic [cfwr_pkg::WORD_W-1:0]      data
);

	logic                        valid_q;
	logic [cfwr_pkg::WORD_W-1:0] data_q;
	logic                        tail;
	logic                        match;

	assign tail  = prev_valid && !valid_q;
	assign match = valid_q && (data_q == ctrl.value);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctrl.deq) begin
			valid_q <= next_valid;
		end else if (ctrl.enq && tail) begin
			valid_q <= 1'b1;
		end
	end

	// advance towards the head on dequeue; else take an enqueued word at the tail or a replacement on a match
	always_ff @(posedge clk) begin
		if (ctrl.deq) begin
			data_q <= next_data;
		end else if (ctrl.enq && tail) begin
			data_q <= ctrl.value;
		end else if (ctrl.rep && match) begin
			data_q <= ctrl.new_value;
		end
	end

	assign valid = valid_q;
	assign data  = data_q;

endmodule

// ===== hdl/cfwr_checker.sv =====
// Port-level checks for circular_fifo_with_replace, attached by bind.
// Depends on cfwr_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module cfwr_checker #(
	parameter int unsigned DEPTH = 128
) (
	input logic               clk,
	input logic               arst_n,
	input logic               req_stall,
	input logic               rsp_valid,
	input logic               rsp_stall,
	input logic signed [31:0] read_data,
	input logic [1:0]         status,
	input logic [7:0]         occupancy
);

	localparam logic [7:0] FULL_OCC = 8'(DEPTH);

	logic rsp_held;
	logic overflow;
	logic underflow;

	assign rsp_held  = rsp_valid && rsp_stall;
	assign overflow  = rsp_valid && (status == cfwr_pkg::ST_OVERFLOW);
	assign underflow = rsp_valid && (status == cfwr_pkg::ST_UNDERFLOW);

	`ASSERT_NEXT(a_rsp_hold, clk, arst_n, rsp_held, rsp_valid && $stable(read_data) && $stable(occupancy), "stalled result changed")
	`ASSERT_IMPLY(a_overflow_full, clk, arst_n, overflow, occupancy == FULL_OCC, "overflow while not full")
	`ASSERT_IMPLY(a_underflow_empty, clk, arst_n, underflow, (occupancy == 8'd0) && (read_data == -32'sd1), "bad underflow result")
	`ASSERT_IMPLY(a_stall_cause, clk, arst_n, req_stall, rsp_valid && rsp_stall, "request stalled without a held result")

endmodule

bind circular_fifo_with_replace cfwr_checker #(.DEPTH(DEPTH)) u_cfwr_checker (.*);

// ===== test/tb_top.sv =====
// Testbench for circular_fifo_with_replace: random enqueue, dequeue and replace traffic
// with random gaps on both handshakes, checked against a ring-buffer tracker.
// Depends on cfwr_pkg and the circular_fifo_with_replace RTL.
`timescale 1ns / 1ps

module tb_top;

	localparam int unsigned FIFO_DEPTH  = 128;
	localparam logic [1:0]  FUNC_SPARE  = 2'd3;
	localparam int unsigned ITEM_TARGET = 1500;

	typedef struct {
		logic [31:0] read_data;
		logic [1:0]  status;
		logic [7:0]  occupancy;
	} fifo_result_t;

	class fifo_ledger;
		logic [31:0]   slots [FIFO_DEPTH];
		int unsigned   head_ptr, tail_ptr, held;
		fifo_result_t  due_results [$];
		int unsigned   mismatches, requests, overflows, underflows, rewrites, peak;

		function void reset_state();
			head_ptr = 0;
			tail_ptr = 0;
			held     = 0;
			due_results.delete();
		endfunction

		// work out the result of one request transfer and advance the queue
		function void log_request(logic [1:0] f, logic [31:0] v, logic [31:0] nv);
			fifo_result_t r;
			int unsigned  i;
			int unsigned  k;
			r.read_data = '0;
			r.status    = cfwr_pkg::ST_OK;
			requests++;
			case (f)
				cfwr_pkg::FUNC_ENQ: begin
					if (held >= FIFO_DEPTH) begin
						r.status = cfwr_pkg::ST_OVERFLOW;
						overflows++;
					end else begin
						slots[tail_ptr] = v;
						tail_ptr = (tail_ptr + 1) % FIFO_DEPTH;
						held++;
					end
				end
				cfwr_pkg::FUNC_DEQ: begin
					if (held == 0) begin
						r.read_data = cfwr_pkg::UNDERFLOW_WORD;
						r.status    = cfwr_pkg::ST_UNDERFLOW;
						underflows++;
					end else begin
						r.read_data = slots[head_ptr];
						head_ptr = (head_ptr + 1) % FIFO_DEPTH;
						held--;
					end
				end
				cfwr_pkg::FUNC_REP: begin
					i = head_ptr;
					for (k = 0; k < held; k++) begin
						if (slots[i] == v) begin
							slots[i] = nv;
							rewrites++;
						end
						i = (i + 1) % FIFO_DEPTH;
					end
				end
				default: ;
			endcase
			if (held > peak)
				peak = held;
			r.occupancy = 8'(held);
			due_results.push_back(r);
		endfunction

		task report(string what, logic [31:0] got, logic [31:0] want);
			mismatches++;
			$display("%0t mismatch %s: got %h want %h", $time, what, got, want);
		endtask

		task check_result(logic [31:0] rd, logic [1:0] st, logic [7:0] occ);
			fifo_result_t e;
			if (due_results.size() == 0) begin
				report("result with nothing outstanding", {22'd0, st, occ}, '0);
				return;
			end
			e = due_results.pop_front();
			if (rd !== e.read_data)
				report("read_data", rd, e.read_data);
			if (st !== e.status)
				report("status", 32'(st), 32'(e.status));
			if (occ !== e.occupancy)
				report("occupancy", 32'(occ), 32'(e.occupancy));
		endtask
	endclass

	logic               clk;
	logic               arst_n;
	logic               req_valid;
	logic               req_stall;
	logic [1:0]         func;
	logic signed [31:0] value;
	logic signed [31:0] new_value;
	logic               rsp_valid;
	logic               rsp_stall;
	logic signed [31:0] read_data;
	logic [1:0]         status;
	logic [7:0]         occupancy;

	fifo_ledger  ledger = new;
	bit          req_gaps_on;
	int unsigned sent;

	logic [31:0] word_pool [8] = '{32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h0,
		32'h1, 32'd100, 32'h5A5A_5A5A, 32'hA5A5_A5A5};

	circular_fifo_with_replace #(
		.DEPTH(FIFO_DEPTH)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.func(func),
		.value(value),
		.new_value(new_value),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.read_data(read_data),
		.status(status),
		.occupancy(occupancy)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("FAIL circular_fifo_with_replace");
		$finish;
	end

	function logic [31:0] pick_word();
		if ($urandom_range(0, 1) == 0)
			return word_pool[$urandom_range(0, 7)];
		return $urandom();
	endfunction

	task send_request(logic [1:0] f, logic [31:0] v, logic [31:0] nv);
		int unsigned gap;
		gap = req_gaps_on ? $urandom_range(0, 10) : 0;
		repeat (gap) begin
			@(negedge clk);
			req_valid <= 1'b0;
		end
		@(negedge clk);
		req_valid <= 1'b1;
		func      <= f;
		value     <= v;
		new_value <= nv;
		do
			@(posedge clk);
		while (req_stall);
		ledger.log_request(f, v, nv);
		sent++;
	endtask

	// result side: wait a random number of cycles, then take one transfer
	initial begin
		int unsigned wait_cycles;
		int unsigned taken;
		bit          rsp_gaps_on;
		rsp_stall   = 1'b0;
		rsp_gaps_on = 1'b1;
		taken       = 0;
		@(posedge arst_n);
		forever begin
			if (taken % 120 == 0)
				rsp_gaps_on = ($urandom_range(0, 3) != 0);
			wait_cycles = rsp_gaps_on ? $urandom_range(0, 10) : 0;
			repeat (wait_cycles) begin
				@(negedge clk);
				rsp_stall <= 1'b1;
			end
			@(negedge clk);
			rsp_stall <= 1'b0;
			do
				@(posedge clk);
			while (!rsp_valid);
			ledger.check_result(read_data, status, occupancy);
			taken++;
		end
	end

	initial begin
		int unsigned mode;
		int unsigned burst;
		int unsigned pick;
		logic [1:0]  f;
		arst_n      = 1'b0;
		req_valid   = 1'b0;
		func        = cfwr_pkg::FUNC_ENQ;
		value       = '0;
		new_value   = '0;
		req_gaps_on = 1'b1;
		sent        = 0;
		ledger.reset_state();
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// empty queue corners
		send_request(cfwr_pkg::FUNC_DEQ, 32'h1234_5678, 32'h0);
		send_request(cfwr_pkg::FUNC_REP, 32'h0, 32'h1);
		send_request(FUNC_SPARE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		// extremes, duplicates and replace over several matches
		send_request(cfwr_pkg::FUNC_ENQ, 32'h8000_0000, 32'h0);
		send_request(cfwr_pkg::FUNC_ENQ, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
		send_request(cfwr_pkg::FUNC_ENQ, 32'hFFFF_FFFF, 32'h0);
		send_request(cfwr_pkg::FUNC_ENQ, 32'h0, 32'h8000_0000);
		send_request(cfwr_pkg::FUNC_ENQ, 32'h7FFF_FFFF, 32'h0);
		send_request(cfwr_pkg::FUNC_REP, 32'h7FFF_FFFF, 32'h8000_0000);
		send_request(cfwr_pkg::FUNC_REP, 32'h1357_9BDF, 32'h2468_ACE0);
		send_request(cfwr_pkg::FUNC_REP, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_request(FUNC_SPARE, 32'h5555_5555, 32'hAAAA_AAAA);
		send_request(cfwr_pkg::FUNC_REP, 32'h8000_0000, 32'h0);
		repeat (5)
			send_request(cfwr_pkg::FUNC_DEQ, 32'h0, 32'h0);
		send_request(cfwr_pkg::FUNC_DEQ, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_request(cfwr_pkg::FUNC_ENQ, 32'hFFFF_FFFF, 32'h0);
		send_request(cfwr_pkg::FUNC_DEQ, 32'h0, 32'h0);

		// bursts that lean towards filling, draining or neither
		mode = 0;
		while (sent < ITEM_TARGET) begin
			burst       = $urandom_range(100, 250);
			req_gaps_on = ($urandom_range(0, 3) != 0);
			repeat (burst) begin
				pick = $urandom_range(0, 99);
				if (pick < 2)
					f = FUNC_SPARE;
				else if (pick < 16)
					f = cfwr_pkg::FUNC_REP;
				else if (mode == 0)
					f = (pick < 88) ? cfwr_pkg::FUNC_ENQ : cfwr_pkg::FUNC_DEQ;
				else if (mode == 1)
					f = (pick < 28) ? cfwr_pkg::FUNC_ENQ : cfwr_pkg::FUNC_DEQ;
				else
					f = (pick < 58) ? cfwr_pkg::FUNC_ENQ : cfwr_pkg::FUNC_DEQ;
				send_request(f, pick_word(), pick_word());
			end
			mode = $urandom_range(0, 2);
		end
		@(negedge clk);
		req_valid <= 1'b0;

		while (ledger.due_results.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);

		$display("covered %0d requests: %0d overflows, %0d underflows, %0d words replaced",
			ledger.requests, ledger.overflows, ledger.underflows, ledger.rewrites);
		$display("peak occupancy %0d of %0d, %0d mismatches", ledger.peak, FIFO_DEPTH,
			ledger.mismatches);
		if (ledger.mismatches == 0)
			$display("PASS circular_fifo_with_replace");
		else
			$display("FAIL circular_fifo_with_replace");
		$finish;
	end

endmodule

// ===== sim.f =====
+incdir+hdl
hdl/cfwr_pkg.sv
hdl/cfwr_cell.sv
hdl/circular_fifo_with_replace.sv
hdl/cfwr_checker.sv
test/tb_top.sv
